[design/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 byte stream decoder
// Field widths, lead byte masks and the result record passed between stages.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned LEN_W  = 3;
   localparam int unsigned LEFT_W = 2;

   // Payload masks for the lead byte and continuation bytes
   localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'h1F;
   localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'h0F;
   localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'h07;
   localparam logic [BYTE_W-1:0] MASK_CONT  = 8'h3F;

   // Lead byte range boundaries
   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF8;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
   } rsp_type;

   // Sequence length implied by a lead byte
   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] len;
      if (b < LEAD2_LO) begin
         len = LEN_W'(1);
      end else if (b < LEAD3_LO) begin
         len = LEN_W'(2);
      end else if (b < LEAD4_LO) begin
         len = LEN_W'(3);
      end else if (b < LEAD4_HI) begin
         len = LEN_W'(4);
      end else begin
         len = LEN_W'(1);
      end
      return len;
   endfunction

   // Place a 6-bit group (or lead payload) at position 6*pos within the code point
   function automatic logic [CP_W-1:0] place_bits(input logic [BYTE_W-1:0] bits,
                                                   input logic [LEFT_W-1:0] pos);
      logic [CP_W-1:0] wide;
      logic [CP_W-1:0] placed;
      wide = CP_W'(bits);
      case (pos)
         2'd0:    placed = wide;
         2'd1:    placed = wide << 6;
         2'd2:    placed = wide << 12;
         default: placed = wide << 18;
      endcase
      return placed;
   endfunction

endpackage

[design/utf8d_in_reg.sv]
// ----------------------------------------------------------------------------
// utf8d_in_reg: request input register
// Captures one byte per cycle while req_ready is high and holds it until the decode stage takes it.
// ----------------------------------------------------------------------------
module utf8d_in_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [utf8d_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                          byte_valid,
   output logic [utf8d_pkg::BYTE_W-1:0]  byte_data,
   input  logic                          byte_take
);

   logic                         valid_ff, valid_in;
   logic [utf8d_pkg::BYTE_W-1:0] byte_ff, byte_in;

   // Accept when empty or when the held byte leaves this cycle
   assign req_ready = !valid_ff || byte_take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (byte_take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

[design/utf8d_core.sv]
// ----------------------------------------------------------------------------
// utf8d_core: sequence decode
// Tracks the open sequence and assembles the code point one byte at a time.
// ----------------------------------------------------------------------------
module utf8d_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [utf8d_pkg::BYTE_W-1:0]  byte_data,
   output logic                          res_valid,
   output utf8d_pkg::rsp_type            res_data
);

   logic [utf8d_pkg::LEFT_W-1:0] left_ff, left_in;
   logic [utf8d_pkg::CP_W-1:0]   partial_ff, partial_in;
   logic [utf8d_pkg::LEN_W-1:0]  length_ff, length_in;

   logic [utf8d_pkg::LEN_W-1:0]  lead_len;
   logic [utf8d_pkg::BYTE_W-1:0] payload;
   logic [utf8d_pkg::LEFT_W-1:0] left_dec;
   logic [utf8d_pkg::CP_W-1:0]   merged;

   assign lead_len = utf8d_pkg::lead_length(byte_data);
   assign left_dec = left_ff - utf8d_pkg::LEFT_W'(1);
   assign merged   = partial_ff
                   | utf8d_pkg::place_bits(byte_data & utf8d_pkg::MASK_CONT, left_dec);

   // Pick lead payload bits by sequence length
   always_comb begin
      case (lead_len)
         3'd2:    payload = byte_data & utf8d_pkg::MASK_LEAD2;
         3'd3:    payload = byte_data & utf8d_pkg::MASK_LEAD3;
         default: payload = byte_data & utf8d_pkg::MASK_LEAD4;
      endcase
   end

   // Advance the sequence state and form the result
   always_comb begin
      left_in             = left_ff;
      partial_in          = partial_ff;
      length_in           = length_ff;
      res_valid           = 1'b0;
      res_data.code_point = utf8d_pkg::CP_W'(byte_data);
      res_data.seq_length = utf8d_pkg::LEN_W'(1);
      if (step) begin
         if (left_ff == '0) begin
            if (lead_len == utf8d_pkg::LEN_W'(1)) begin
               res_valid = 1'b1;
            end else begin
               left_in    = utf8d_pkg::LEFT_W'(lead_len - utf8d_pkg::LEN_W'(1));
               length_in  = lead_len;
               partial_in = utf8d_pkg::place_bits(payload, left_in);
            end
         end else begin
            left_in    = left_dec;
            partial_in = merged;
            if (left_dec == '0) begin
               res_valid           = 1'b1;
               res_data.code_point = merged;
               res_data.seq_length = length_ff;
               partial_in          = '0;
               length_in           = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         partial_ff <= '0;
         length_ff  <= '0;
      end else begin
         left_ff    <= left_in;
         partial_ff <= partial_in;
         length_ff  <= length_in;
      end
   end

endmodule

[design/utf8d_out_reg.sv]
// ----------------------------------------------------------------------------
// utf8d_out_reg: response output register
// Holds one decoded code point until the consumer takes it.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  utf8d_pkg::rsp_type            res_data,
   output logic                          out_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utf8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic [utf8d_pkg::LEN_W-1:0]   rsp_seq_length
);

   logic               valid_ff, valid_in;
   utf8d_pkg::rsp_type data_ff, data_in;

   // Free when empty or when the held response drains this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (res_valid) begin
         valid_in = 1'b1;
         data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = data_ff.code_point;
   assign rsp_seq_length = data_ff.seq_length;

endmodule

[design/utf8_byte_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder: UTF-8 byte stream to code point decoder
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   req     | in        | req_valid, req_ready, req_in_byte[7:0]
//   rsp     | out       | rsp_valid, rsp_ready, rsp_code_point[20:0],
//           |           | rsp_seq_length[2:0]
//
// One byte is accepted per cycle while req_ready is high. A byte is held in
// the input register and is decoded on its way into the output register,
// so the byte that completes a sequence passes the input register and then
// the output register before its response is valid.
// Sustained rate is one byte per cycle while rsp does not stall, set by the single decode step.
// Synchronous reset closes any open sequence and empties both registers.
// A stall on rsp holds the output register and backs up into req_ready.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [utf8d_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utf8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic [utf8d_pkg::LEN_W-1:0]   rsp_seq_length
);

   logic                         byte_valid;
   logic [utf8d_pkg::BYTE_W-1:0] byte_data;
   logic                         out_free;
   logic                         step;
   logic                         res_valid;
   utf8d_pkg::rsp_type           res_data;

   // Decode a held byte whenever the output register can take its result
   assign step = byte_valid && out_free;

   utf8d_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data),
      .byte_take   (step)
   );

   utf8d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .byte_data (byte_data),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   utf8d_out_reg u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .res_valid      (res_valid),
      .res_data       (res_data),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length)
   );

endmodule
